@@ src/ctm_pkg.sv @@
// shared types and constants for the command line tokenizer and name matcher
`timescale 1ns / 1ps

package ctm_pkg;

   localparam int NumSlots     = 8;
   localparam int SlotIdxWidth = 3;
   localparam int NameBytes    = 8;
   localparam int CsrWidth     = 64;
   localparam int LenWidth     = 4;

   // first word length saturates here, one past the longest possible name
   localparam logic [LenWidth-1:0] FirstLenSat = 4'd9;

   typedef logic [7:0] char_type;
   typedef logic [NameBytes-1:0][7:0] name_type;
   typedef name_type [NumSlots-1:0] name_array_type;
   typedef logic [NumSlots-1:0] slot_mask_type;
   typedef logic [SlotIdxWidth-1:0] slot_idx_type;
   typedef logic [LenWidth-1:0] len_type;

   typedef enum logic {
      KIND_WORD_CHAR = 1'b0,
      KIND_SUMMARY   = 1'b1
   } result_kind_type;

   // what the matcher reports to the tokenizer each cycle
   typedef struct packed {
      slot_mask_type char_miss;
      logic          hit;
      slot_idx_type  slot;
   } match_type;

endpackage

@@ src/ctm_chan_if.sv @@
// request and response channel interfaces
`timescale 1ns / 1ps

interface ctm_req_if;
   logic             valid;
   logic             ready;
   ctm_pkg::char_type in_char;

   modport source (output valid, output in_char, input ready);
   modport sink (input valid, input in_char, output ready);
endinterface

interface ctm_rsp_if;
   logic                 valid;
   logic                 ready;
   logic                 result_kind;
   logic [2:0]           word_index;
   ctm_pkg::char_type    word_char;
   logic [3:0]           word_count;
   logic                 name_matched;
   ctm_pkg::slot_idx_type matched_slot;

   modport source (output valid, output result_kind, output word_index, output word_char,
                   output word_count, output name_matched, output matched_slot,
                   input ready);
   modport sink (input valid, input result_kind, input word_index, input word_char,
                 input word_count, input name_matched, input matched_slot,
                 output ready);
endinterface

@@ src/command_line_tokenizer_matcher.sv @@
// top level: command line tokenizer with first word name matching
//
// Characters arrive one per request on req_chan. Every character that ends up
// in a word (escapes and quotes removed) gives one response on rsp_chan with
// its word index. The end of line character gives one summary response with
// the word count and the lowest name slot whose name equals the first word.
// Separators, quote and escape marks, characters past the line length limit
// and characters of words past the word limit give no response.
// Name slots are written through csr_write_en / csr_index / csr_write_data;
// the user must write them only while the block is idle (not enforced).
// Each response appears in the cycle after its request is accepted.
// Throughput: one request per cycle unless rsp_chan stalls; state updates and
// the eight byte compares sit between the request handshake and the response
// register. A stalled response register holds its value; a new request is
// taken in the same cycle the held response leaves, so a stall on rsp_chan
// backs up req_chan by exactly that one register.
// Reset clears the line state, the response valid flag and all name slots.
`timescale 1ns / 1ps

module command_line_tokenizer_matcher #(
   parameter int LINE_LENGTH      = 64,
   parameter int MAX_WORDS        = 8,
   parameter int END_OF_LINE_CHAR = 10,
   parameter int ESCAPE_CHAR      = 92,
   parameter int QUOTE_CHAR       = 34
) (
   input  logic                              clock,
   input  logic                              reset,
   ctm_req_if.sink                           req_chan,
   ctm_rsp_if.source                         rsp_chan,
   input  logic                              csr_write_en,
   input  logic [ctm_pkg::SlotIdxWidth-1:0]  csr_index,
   input  logic [ctm_pkg::CsrWidth-1:0]      csr_write_data
);

   localparam ctm_pkg::char_type EolChar    = 8'(END_OF_LINE_CHAR);
   localparam ctm_pkg::char_type EscChar    = 8'(ESCAPE_CHAR);
   localparam ctm_pkg::char_type QuoteChar  = 8'(QUOTE_CHAR);
   localparam logic [6:0]        LineLimit  = 7'(LINE_LENGTH);
   localparam logic [3:0]        WordLimit  = 4'(MAX_WORDS);

   ctm_pkg::name_array_type names_ff;

   logic [6:0]             line_pos_ff, line_pos_in;
   logic                   esc_ff, esc_in;
   logic                   quotes_ff, quotes_in;
   logic                   in_word_ff, in_word_in;
   logic [3:0]             words_ff, words_in;
   ctm_pkg::len_type       first_len_ff, first_len_in;
   ctm_pkg::slot_mask_type still_ff, still_in;

   logic                   rsp_valid_ff;
   logic                   rsp_kind_ff;
   logic [2:0]             rsp_index_ff;
   ctm_pkg::char_type      rsp_char_ff;
   logic [3:0]             rsp_count_ff;
   logic                   rsp_matched_ff;
   ctm_pkg::slot_idx_type  rsp_slot_ff;

   ctm_pkg::char_type  c;
   ctm_pkg::match_type match;
   logic accept, is_eol, over, is_esc, is_quote, is_blank, is_word_char;
   logic start_word, drop_word, emit_char, first_word;
   logic [3:0] words_next;
   logic [2:0] word_idx;

   ctm_name_match u_match (
      .names          (names_ff),
      .in_char        (c),
      .first_len      (first_len_ff),
      .still_matching (still_ff),
      .match          (match)
   );

   assign c              = req_chan.in_char;
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   assign is_eol   = c == EolChar;
   assign over     = line_pos_ff >= LineLimit;
   assign is_esc   = c == EscChar && !esc_ff;
   assign is_quote = c == QuoteChar && !esc_ff;
   assign is_blank = ((c >= 8'h09 && c <= 8'h0d) || c == 8'h20) && !esc_ff && !quotes_ff;

   assign is_word_char = !is_eol && !over && !is_esc && !is_quote && !is_blank;
   assign start_word   = is_word_char && !in_word_ff;
   assign drop_word    = start_word && words_ff >= WordLimit;
   assign emit_char    = is_word_char && !drop_word;
   assign words_next   = words_ff + 4'(start_word && !drop_word);
   assign word_idx     = 3'(words_next - 4'd1);
   assign first_word   = emit_char && words_next == 4'd1;

   always_comb begin
      line_pos_in  = line_pos_ff;
      esc_in       = esc_ff;
      quotes_in    = quotes_ff;
      in_word_in   = in_word_ff;
      words_in     = words_ff;
      first_len_in = first_len_ff;
      still_in     = still_ff;
      if (accept) begin
         if (is_eol) begin
            line_pos_in  = '0;
            esc_in       = 1'b0;
            quotes_in    = 1'b0;
            in_word_in   = 1'b0;
            words_in     = '0;
            first_len_in = '0;
            still_in     = '1;
         end else if (!over) begin
            line_pos_in = line_pos_ff + 7'd1;
            if (is_esc) begin
               esc_in = 1'b1;
            end else if (is_quote) begin
               quotes_in = !quotes_ff;
            end else if (is_blank) begin
               in_word_in = 1'b0;
            end else begin
               esc_in = 1'b0;
               if (!drop_word) begin
                  in_word_in = 1'b1;
                  words_in   = words_next;
               end
               if (first_word) begin
                  if (!first_len_ff[3]) begin
                     still_in = still_ff & ~match.char_miss;
                  end
                  if (first_len_ff != ctm_pkg::FirstLenSat) begin
                     first_len_in = first_len_ff + 4'd1;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_pos_ff  <= '0;
         esc_ff       <= 1'b0;
         quotes_ff    <= 1'b0;
         in_word_ff   <= 1'b0;
         words_ff     <= '0;
         first_len_ff <= '0;
         still_ff     <= '1;
      end else begin
         line_pos_ff  <= line_pos_in;
         esc_ff       <= esc_in;
         quotes_ff    <= quotes_in;
         in_word_ff   <= in_word_in;
         words_ff     <= words_in;
         first_len_ff <= first_len_in;
         still_ff     <= still_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         names_ff <= '0;
      end else if (csr_write_en) begin
         names_ff[csr_index] <= csr_write_data;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= is_eol || emit_char;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         if (is_eol) begin
            rsp_kind_ff    <= ctm_pkg::KIND_SUMMARY;
            rsp_index_ff   <= '0;
            rsp_char_ff    <= '0;
            rsp_count_ff   <= words_ff;
            // a match needs a first word of at most eight characters
            rsp_matched_ff <= match.hit && words_ff != 4'd0 && first_len_ff <= 4'd8;
            rsp_slot_ff    <= (match.hit && words_ff != 4'd0 && first_len_ff <= 4'd8) ?
                              match.slot : '0;
         end else begin
            rsp_kind_ff    <= ctm_pkg::KIND_WORD_CHAR;
            rsp_index_ff   <= word_idx;
            rsp_char_ff    <= c;
            rsp_count_ff   <= '0;
            rsp_matched_ff <= 1'b0;
            rsp_slot_ff    <= '0;
         end
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.result_kind  = rsp_kind_ff;
   assign rsp_chan.word_index   = rsp_index_ff;
   assign rsp_chan.word_char    = rsp_char_ff;
   assign rsp_chan.word_count   = rsp_count_ff;
   assign rsp_chan.name_matched = rsp_matched_ff;
   assign rsp_chan.matched_slot = rsp_slot_ff;

   a_eol_gives_summary : assert property (@(posedge clock) disable iff (reset)
      accept && is_eol |=> rsp_chan.valid && rsp_chan.result_kind == ctm_pkg::KIND_SUMMARY)
      else $error("end of line request without summary response");

   a_words_bounded : assert property (@(posedge clock) disable iff (reset)
      words_ff <= WordLimit)
      else $error("word count past limit");

   a_line_bounded : assert property (@(posedge clock) disable iff (reset)
      line_pos_ff <= LineLimit)
      else $error("line position past limit");

   a_match_needs_word : assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.result_kind == ctm_pkg::KIND_SUMMARY && rsp_chan.name_matched
      |-> rsp_chan.word_count != 4'd0)
      else $error("name match reported on empty line");

endmodule

@@ src/ctm_name_match.sv @@
// per-character compare against the name slots and end of line slot pick
`timescale 1ns / 1ps

module ctm_name_match (
   input  ctm_pkg::name_array_type names,
   input  ctm_pkg::char_type       in_char,
   input  ctm_pkg::len_type        first_len,
   input  ctm_pkg::slot_mask_type  still_matching,
   output ctm_pkg::match_type      match
);

   ctm_pkg::len_type      name_len [ctm_pkg::NumSlots];
   ctm_pkg::slot_mask_type full_hit;
   ctm_pkg::slot_mask_type miss;

   // name length is the position of the first zero byte
   always_comb begin
      for (int s = 0; s < ctm_pkg::NumSlots; s++) begin
         name_len[s] = ctm_pkg::LenWidth'(ctm_pkg::NameBytes);
         for (int b = ctm_pkg::NameBytes - 1; b >= 0; b--) begin
            if (names[s][b] == 8'd0) begin
               name_len[s] = ctm_pkg::LenWidth'(b);
            end
         end
      end
   end

   always_comb begin
      for (int s = 0; s < ctm_pkg::NumSlots; s++) begin
         miss[s] = names[s][first_len[2:0]] != in_char;
         full_hit[s] = still_matching[s] && (name_len[s] == first_len);
      end
   end

   // lowest slot wins
   always_comb begin
      match.char_miss = miss;
      match.hit  = 1'b0;
      match.slot = '0;
      for (int s = ctm_pkg::NumSlots - 1; s >= 0; s--) begin
         if (full_hit[s]) begin
            match.hit  = 1'b1;
            match.slot = ctm_pkg::SlotIdxWidth'(s);
         end
      end
   end

endmodule

@@ bench/tb_command_line_tokenizer_matcher.sv @@
// testbench for the command line tokenizer: directed and random lines checked against a predictor of the tokens
`timescale 1ns / 1ps

module tb_command_line_tokenizer_matcher;

   localparam int                LineLength    = 64;
   localparam int                MaxWords      = 8;
   localparam ctm_pkg::char_type EolChar       = 8'h0A;
   localparam ctm_pkg::char_type EscChar       = 8'h5C;
   localparam ctm_pkg::char_type QuoteChar     = 8'h22;
   localparam int                ItemsPerPhase = 175;
   localparam int                NumPhases     = 8;
   localparam int                HoldCycles    = 300;

   typedef struct packed {
      ctm_pkg::result_kind_type kind;
      logic [2:0]               index;
      ctm_pkg::char_type        ch;
      logic [3:0]               count;
      logic                     matched;
      ctm_pkg::slot_idx_type    slot;
   } token_type;

   logic clock;
   logic reset;
   logic csr_write_en;
   ctm_pkg::slot_idx_type csr_index;
   logic [ctm_pkg::CsrWidth-1:0] csr_write_data;

   ctm_req_if req_chan ();
   ctm_rsp_if rsp_chan ();

   command_line_tokenizer_matcher #(
      .LINE_LENGTH     (LineLength),
      .MAX_WORDS       (MaxWords),
      .END_OF_LINE_CHAR(EolChar),
      .ESCAPE_CHAR     (EscChar),
      .QUOTE_CHAR      (QuoteChar)
   ) i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_chan      (req_chan),
      .rsp_chan      (rsp_chan),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_write_data(csr_write_data)
   );

   // predictor state
   ctm_pkg::name_array_type slot_names;
   int                      line_pos;
   bit                      esc_pending;
   bit                      in_quotes;
   bit                      in_word;
   logic [3:0]              words_cnt;
   ctm_pkg::len_type        first_len;
   ctm_pkg::slot_mask_type  still_match;

   ctm_pkg::char_type line_chars_q[$];
   token_type expected_token_q[$];
   int        chars_pushed;
   int        chars_taken;
   int        error_count;
   int        send_idle_pct;
   int        stall_pct;
   int        hold_left;
   bit        hold_arm;
   bit        req_taken;
   int        phase_end;
   token_type want;
   token_type got;
   bit        made;

   always begin
      #4 clock = ~clock;
   end

   function automatic bit is_blank(input ctm_pkg::char_type c);
      return (c >= 8'h09 && c <= 8'h0D) || c == 8'h20;
   endfunction

   function automatic int name_len(input ctm_pkg::name_type v);
      int n;
      n = 0;
      while (n < ctm_pkg::NameBytes && v[n] != 8'h00) n++;
      return n;
   endfunction

   function automatic void clear_line();
      line_pos    = 0;
      esc_pending = 0;
      in_quotes   = 0;
      in_word     = 0;
      words_cnt   = '0;
      first_len   = '0;
      still_match = '1;
   endfunction

   function automatic void tokenize_char(input ctm_pkg::char_type c, output bit produced,
                                         output token_type r);
      int idx;
      produced = 0;
      r = '0;
      if (c == EolChar) begin
         r.kind  = ctm_pkg::KIND_SUMMARY;
         r.count = words_cnt;
         if (words_cnt > 0 && first_len <= ctm_pkg::NameBytes) begin
            for (int s = 0; s < ctm_pkg::NumSlots; s++) begin
               if (!r.matched && still_match[s] && name_len(slot_names[s]) == first_len) begin
                  r.matched = 1'b1;
                  r.slot    = ctm_pkg::slot_idx_type'(s);
               end
            end
         end
         produced = 1;
         clear_line();
         return;
      end
      if (line_pos >= LineLength) return;
      line_pos++;
      if (c == EscChar && !esc_pending) begin
         esc_pending = 1;
         return;
      end
      if (c == QuoteChar && !esc_pending) begin
         in_quotes = !in_quotes;
         return;
      end
      if (is_blank(c) && !esc_pending && !in_quotes) begin
         in_word = 0;
         return;
      end
      esc_pending = 0;
      if (!in_word) begin
         if (words_cnt >= MaxWords) return;
         words_cnt++;
         in_word = 1;
      end
      idx = words_cnt - 1;
      if (idx == 0) begin
         // each slot is compared with its current value at this character
         if (first_len < ctm_pkg::NameBytes) begin
            for (int s = 0; s < ctm_pkg::NumSlots; s++)
               if (slot_names[s][first_len] != c) still_match[s] = 1'b0;
         end
         if (first_len < ctm_pkg::FirstLenSat) first_len++;
      end
      r.kind   = ctm_pkg::KIND_WORD_CHAR;
      r.index  = 3'(idx);
      r.ch     = c;
      produced = 1;
   endfunction

   task automatic check_field(input string fname, input logic [7:0] exp_v,
                              input logic [7:0] act_v);
      if (act_v !== exp_v) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, fname, exp_v, act_v);
      end
   endtask

   // request acceptance, csr tracking and response checking
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
         slot_names = '0;
         clear_line();
      end else begin
         req_taken <= req_chan.valid && req_chan.ready;
         if (csr_write_en) slot_names[csr_index] = csr_write_data;
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.kind    = ctm_pkg::result_kind_type'(rsp_chan.result_kind);
            got.index   = rsp_chan.word_index;
            got.ch      = rsp_chan.word_char;
            got.count   = rsp_chan.word_count;
            got.matched = rsp_chan.name_matched;
            got.slot    = rsp_chan.matched_slot;
            if (expected_token_q.size() == 0) begin
               error_count++;
               $display("%0t: response with none expected, expected none actual kind %0h char %0h",
                        $time, got.kind, got.ch);
            end else begin
               want = expected_token_q.pop_front();
               check_field("result_kind", 8'(want.kind), 8'(got.kind));
               check_field("word_index", 8'(want.index), 8'(got.index));
               check_field("word_char", want.ch, got.ch);
               check_field("word_count", 8'(want.count), 8'(got.count));
               check_field("name_matched", 8'(want.matched), 8'(got.matched));
               check_field("matched_slot", 8'(want.slot), 8'(got.slot));
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            chars_taken++;
            tokenize_char(req_chan.in_char, made, want);
            if (made) expected_token_q.push_back(want);
         end
      end
   end

   // request driver
   always @(negedge clock) begin
      if (!reset && (!req_chan.valid || req_taken)) begin
         if (line_chars_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_chan.valid   <= 1'b1;
            req_chan.in_char <= line_chars_q.pop_front();
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // response sink with random stalls and one long hold-off
   always @(negedge clock) begin
      rsp_chan.ready <= !reset && hold_left == 0 && $urandom_range(99) >= stall_pct;
   end

   always @(posedge clock) begin
      if (hold_arm) begin
         hold_left <= HoldCycles;
         hold_arm  <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   task automatic push_char(input ctm_pkg::char_type c);
      line_chars_q.push_back(c);
      chars_pushed++;
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) push_char(s[i]);
   endtask

   function automatic ctm_pkg::char_type random_char();
      ctm_pkg::char_type c;
      if ($urandom_range(9) < 7) return 8'h61 + ctm_pkg::char_type'($urandom_range(3));
      do c = ctm_pkg::char_type'($urandom_range(255)); while (c == EolChar);
      return c;
   endfunction

   function automatic ctm_pkg::char_type random_blank();
      ctm_pkg::char_type c;
      c = ctm_pkg::char_type'($urandom_range(8'h09, 8'h0D));
      if (c == EolChar || $urandom_range(1)) c = 8'h20;
      return c;
   endfunction

   function automatic ctm_pkg::name_type random_name();
      ctm_pkg::name_type v;
      int len;
      v   = '0;
      len = $urandom_range(1, ctm_pkg::NameBytes);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(9) < 8) v[i] = 8'h61 + ctm_pkg::char_type'($urandom_range(2));
         else do v[i] = ctm_pkg::char_type'($urandom_range(1, 255)); while (v[i] == EolChar);
      end
      // a zero in the middle cuts the name short
      if (len > 2 && $urandom_range(9) == 0) v[$urandom_range(1, len - 2)] = 8'h00;
      return v;
   endfunction

   task automatic write_reg(input int idx, input ctm_pkg::name_type v);
      @(negedge clock);
      csr_write_en   = 1'b1;
      csr_index      = ctm_pkg::slot_idx_type'(idx);
      csr_write_data = v;
      @(negedge clock);
      csr_write_en = 1'b0;
   endtask

   task automatic program_names(input int style);
      ctm_pkg::name_type v;
      for (int s = 0; s < ctm_pkg::NumSlots; s++) begin
         case (style)
            0: v = random_name();
            1: v = (s == 2 || s == 5) ? '1 : (s == 0 ? 64'h8000_0000_0000_0000 : random_name());
            2: v = (s == ctm_pkg::NumSlots - 1) ? random_name() : '0;
            default: v = (s < 4) ? random_name() : slot_names[s - 4];
         endcase
         write_reg(s, v);
      end
   endtask

   // quote or escape whatever would otherwise split or vanish
   task automatic push_word(input bit first, input bit long_word);
      ctm_pkg::char_type w[$];
      ctm_pkg::name_type nm;
      int len;
      if (first && !long_word && $urandom_range(99) < 60) begin
         nm = slot_names[$urandom_range(ctm_pkg::NumSlots - 1)];
         for (int i = 0; i < ctm_pkg::NameBytes && nm[i] != 8'h00; i++) w.push_back(nm[i]);
         case ($urandom_range(4))
            0: if (w.size() > 0) void'(w.pop_back());
            1: w.push_back(random_char());
            default: ;
         endcase
      end
      if (w.size() == 0) begin
         len = long_word ? $urandom_range(60, 80) : $urandom_range(1, 10);
         for (int i = 0; i < len; i++) w.push_back(random_char());
      end
      foreach (w[i]) begin
         if (w[i] == EscChar || w[i] == QuoteChar) begin
            push_char(EscChar);
            push_char(w[i]);
         end else if (is_blank(w[i])) begin
            if ($urandom_range(1)) begin
               push_char(EscChar);
               push_char(w[i]);
            end else begin
               push_char(QuoteChar);
               push_char(w[i]);
               push_char(QuoteChar);
            end
         end else begin
            case ($urandom_range(9))
               0: begin
                  push_char(QuoteChar);
                  push_char(QuoteChar);
               end
               1: push_char(EscChar);
               default: ;
            endcase
            push_char(w[i]);
         end
      end
   endtask

   task automatic random_line();
      int nwords;
      bit long_line;
      if ($urandom_range(99) < 8) begin
         // raw noise, end of line characters included
         repeat ($urandom_range(1, 20)) push_char(ctm_pkg::char_type'($urandom_range(255)));
      end else begin
         nwords    = $urandom_range(0, 10);
         long_line = $urandom_range(99) < 6;
         if ($urandom_range(4) == 0) push_char(random_blank());
         for (int i = 0; i < nwords; i++) begin
            if (i > 0) repeat ($urandom_range(1, 2)) push_char(random_blank());
            push_word(i == 0, long_line && i == nwords - 1);
         end
         case ($urandom_range(9))
            0: push_char(EscChar);
            1: push_char(QuoteChar);
            2: push_char(random_blank());
            default: ;
         endcase
      end
      push_char(EolChar);
   endtask

   task automatic wait_idle();
      while (chars_taken != chars_pushed || expected_token_q.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   initial begin
      clock            = 1'b0;
      reset            = 1'b1;
      csr_write_en     = 1'b0;
      csr_index        = '0;
      csr_write_data   = '0;
      req_chan.valid   = 1'b0;
      req_chan.in_char = '0;
      rsp_chan.ready   = 1'b0;
      chars_pushed     = 0;
      chars_taken      = 0;
      error_count      = 0;
      send_idle_pct    = 0;
      stall_pct        = 0;
      hold_left        = 0;
      hold_arm         = 1'b0;
      repeat (9) @(negedge clock);
      reset = 1'b0;

      // directed lines
      write_reg(0, '0);
      write_reg(1, 64'h6261);
      write_reg(2, 64'h6261);
      write_reg(3, '1);
      write_reg(4, 64'h61);
      write_reg(5, 64'h0102_0304_0506_0708);
      write_reg(6, '0);
      write_reg(7, 64'h8000_0000_0000_0000);
      push_text("\n");
      push_text("\"\"\n");
      push_text("\\\n");
      push_text("a\"b c\n");
      push_text("ab\n");
      repeat (8) push_char(8'hFF);
      push_char(EolChar);
      push_char(8'h00);
      push_char(EolChar);
      // slot rewritten while a line is open
      push_text("a");
      wait_idle();
      write_reg(4, 64'h62);
      push_char(EolChar);
      wait_idle();

      for (int ph = 0; ph < NumPhases; ph++) begin
         case (ph / 2)
            0: begin
               send_idle_pct = 0;
               stall_pct     = 0;
            end
            1: begin
               send_idle_pct = 47;
               stall_pct     = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct     = 47;
            end
            default: begin
               send_idle_pct = 21;
               stall_pct     = 21;
            end
         endcase
         program_names(ph % 4);
         if (ph == 1) hold_arm = 1'b1;
         phase_end = chars_pushed + ItemsPerPhase;
         while (chars_pushed < phase_end) random_line();
         wait_idle();
      end

      repeat (4) @(posedge clock);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("tb: failure");
      $finish;
   end

endmodule

@@ command_line_tokenizer_matcher.f @@
src/ctm_pkg.sv
src/ctm_chan_if.sv
src/ctm_name_match.sv
src/command_line_tokenizer_matcher.sv
bench/tb_command_line_tokenizer_matcher.sv
